@@ src/aafc_pkg.sv @@
`default_nettype none

package aafc_pkg;

    localparam int unsigned MAX_PLANES = 6;
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned DATA_W     = 64;
    localparam int unsigned PROD_W     = 2 * COORD_W;
    localparam int unsigned FRAC_W     = 8;
    localparam int unsigned ACC_W      = PROD_W + 3;

    typedef enum logic [IDX_W-1:0] {
        REG_PLANE_COUNT = 3'd0,
        REG_PLANE_ZERO  = 3'd1,
        REG_PLANE_ONE   = 3'd2,
        REG_PLANE_TWO   = 3'd3,
        REG_PLANE_THREE = 3'd4,
        REG_PLANE_FOUR  = 3'd5,
        REG_PLANE_FIVE  = 3'd6
    } cfg_reg_t;

    localparam logic [CNT_W-1:0] PLANE_COUNT_RESET = 3'd6;

    typedef logic signed [COORD_W-1:0] q88_t;

    typedef struct packed {
        q88_t offset;
        q88_t nz;
        q88_t ny;
        q88_t nx;
    } plane_t;

    typedef struct packed {
        q88_t max_z;
        q88_t max_y;
        q88_t max_x;
        q88_t min_z;
        q88_t min_y;
        q88_t min_x;
    } box_t;

    typedef struct packed {
        logic [CNT_W-1:0]            plane_count;
        plane_t [MAX_PLANES-1:0]     planes;
    } cfg_t;

endpackage

`default_nettype wire

@@ src/aafc_cfg_regs.sv @@
`default_nettype none

module aafc_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [aafc_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [aafc_pkg::DATA_W-1:0]  cfg_data,
    output aafc_pkg::cfg_t                    cfg
);

    logic [aafc_pkg::CNT_W-1:0]                  count_reg;
    aafc_pkg::plane_t [aafc_pkg::MAX_PLANES-1:0] planes_reg;
    logic [aafc_pkg::IDX_W-1:0]                  plane_sel;
    logic                                        plane_wr;
    logic                                        count_wr;

    assign cfg_ready = 1'b1;
    assign plane_sel = cfg_index - aafc_pkg::REG_PLANE_ZERO;

    always_comb begin
        count_wr = 1'b0;
        plane_wr = 1'b0;
        case (aafc_pkg::cfg_reg_t'(cfg_index))
            aafc_pkg::REG_PLANE_COUNT: begin
                count_wr = cfg_valid;
            end
            aafc_pkg::REG_PLANE_ZERO, aafc_pkg::REG_PLANE_ONE, aafc_pkg::REG_PLANE_TWO,
            aafc_pkg::REG_PLANE_THREE, aafc_pkg::REG_PLANE_FOUR,
            aafc_pkg::REG_PLANE_FIVE: begin
                plane_wr = cfg_valid;
            end
            default: begin
                count_wr = 1'b0;
                plane_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= aafc_pkg::PLANE_COUNT_RESET;
            planes_reg <= '0;
        end else begin
            if (count_wr) begin
                count_reg <= cfg_data[aafc_pkg::CNT_W-1:0];
            end
            for (int p = 0; p < aafc_pkg::MAX_PLANES; p++) begin
                if (plane_wr && plane_sel == aafc_pkg::IDX_W'(p)) begin
                    planes_reg[p] <= cfg_data;
                end
            end
        end
    end

    // Counts above the number of plane lanes saturate.
    always_comb begin
        cfg.planes = planes_reg;
        if (count_reg > aafc_pkg::CNT_W'(aafc_pkg::MAX_PLANES)) begin
            cfg.plane_count = aafc_pkg::CNT_W'(aafc_pkg::MAX_PLANES);
        end else begin
            cfg.plane_count = count_reg;
        end
    end

endmodule

`default_nettype wire

@@ src/aafc_plane_eval.sv @@
`default_nettype none

module aafc_plane_eval (
    input  wire aafc_pkg::box_t   box,
    input  wire aafc_pkg::plane_t plane,
    output logic                  pass
);

    aafc_pkg::q88_t                       n   [3];
    aafc_pkg::q88_t                       lo  [3];
    aafc_pkg::q88_t                       hi  [3];
    aafc_pkg::q88_t                       v   [3];
    logic signed [aafc_pkg::PROD_W-1:0]   prod[3];
    logic signed [aafc_pkg::ACC_W-1:0]    dist_ext;
    logic signed [aafc_pkg::ACC_W-1:0]    acc;

    assign n[0]  = plane.nx;
    assign n[1]  = plane.ny;
    assign n[2]  = plane.nz;
    assign lo[0] = box.min_x;
    assign lo[1] = box.min_y;
    assign lo[2] = box.min_z;
    assign hi[0] = box.max_x;
    assign hi[1] = box.max_y;
    assign hi[2] = box.max_z;

    // The positive vertex takes the max corner only for a strictly positive normal.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            v[a]    = (!n[a][aafc_pkg::COORD_W-1] && n[a] != '0) ? hi[a] : lo[a];
            prod[a] = n[a] * v[a];
        end
    end

    assign dist_ext = aafc_pkg::ACC_W'(plane.offset);
    assign acc = (dist_ext <<< aafc_pkg::FRAC_W)
               + aafc_pkg::ACC_W'(prod[0])
               + aafc_pkg::ACC_W'(prod[1])
               + aafc_pkg::ACC_W'(prod[2]);
    assign pass = !acc[aafc_pkg::ACC_W-1];

endmodule

`default_nettype wire

@@ src/aabb_frustum_cull_test.sv @@
`default_nettype none

// A box accepted into the input register moves into the result register when that is free.
// Throughput: one box per cycle unless m_ready stalls the output; all plane tests run in
// parallel lanes between the input register and the result register, and the input register
// refills as the result register drains.
// Reset: synchronous, active low; both stages empty, plane count 6, all planes zero.
module aabb_frustum_cull_test (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [15:0]           s_box_min_x,
    input  wire logic signed [15:0]           s_box_min_y,
    input  wire logic signed [15:0]           s_box_min_z,
    input  wire logic signed [15:0]           s_box_max_x,
    input  wire logic signed [15:0]           s_box_max_y,
    input  wire logic signed [15:0]           s_box_max_z,
    input  wire logic                         s_last_box,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_inside_res,
    output logic                              m_last_result,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [aafc_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [aafc_pkg::DATA_W-1:0]  cfg_data
);

    aafc_pkg::cfg_t                  cfg;
    aafc_pkg::box_t                  box_reg;
    logic                            in_valid_reg;
    logic                            in_last_reg;
    logic                            out_valid_reg;
    logic                            inside_reg;
    logic                            out_last_reg;
    logic                            advance;
    logic                            inside_next;
    logic [aafc_pkg::MAX_PLANES-1:0] pass;
    logic [aafc_pkg::MAX_PLANES-1:0] active;

    aafc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    for (genvar p = 0; p < aafc_pkg::MAX_PLANES; p++) begin : g_plane
        aafc_plane_eval u_eval (
            .box   (box_reg),
            .plane (cfg.planes[p]),
            .pass  (pass[p])
        );
        assign active[p] = aafc_pkg::CNT_W'(p) < cfg.plane_count;
    end

    assign inside_next = &(pass | ~active);

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            box_reg.min_x <= s_box_min_x;
            box_reg.min_y <= s_box_min_y;
            box_reg.min_z <= s_box_min_z;
            box_reg.max_x <= s_box_max_x;
            box_reg.max_y <= s_box_max_y;
            box_reg.max_z <= s_box_max_z;
            in_last_reg   <= s_last_box;
        end
        if (advance && in_valid_reg) begin
            inside_reg   <= inside_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_inside_res  = inside_reg;
    assign m_last_result = out_last_reg;

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> m_valid)
        else $error("A box in the input stage did not reach the result register.");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("Input was stalled while the pipeline had room.");

    a_no_planes_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance && cfg.plane_count == '0) |=> m_inside_res)
        else $error("A box was culled with no active planes.");

    a_count_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.plane_count <= aafc_pkg::CNT_W'(aafc_pkg::MAX_PLANES))
        else $error("Effective plane count exceeds the number of plane lanes.");

    a_last_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> (m_last_result == $past(in_last_reg)))
        else $error("The last-box marker was not carried with its result.");

endmodule

`default_nettype wire

@@ tb/sv/aabb_frustum_cull_test_test.sv @@
`default_nettype none

module aabb_frustum_cull_test_test;
    import aafc_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic is_in;
        logic last_flag;
    } verdict_t;

    class cull_scoreboard;
        logic [CNT_W-1:0] plane_count;
        plane_t planes [MAX_PLANES];
        verdict_t verdicts_due [$];
        int mismatches;

        function new();
            plane_count = PLANE_COUNT_RESET;
            foreach (planes[p]) planes[p] = '0;
            mismatches = 0;
        endfunction

        function void apply_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_PLANE_COUNT: plane_count = val[CNT_W-1:0];
                REG_PLANE_ZERO, REG_PLANE_ONE, REG_PLANE_TWO,
                REG_PLANE_THREE, REG_PLANE_FOUR, REG_PLANE_FIVE: begin
                    planes[idx - REG_PLANE_ZERO] = plane_t'(val);
                end
                default: ;
            endcase
        endfunction

        // A plane rejects the box when its positive vertex lies behind it.
        function logic box_inside(box_t b);
            longint lo[3];
            longint hi[3];
            longint nrm[3];
            longint acc;
            int live;
            lo[0] = q88_t'(b.min_x);
            lo[1] = q88_t'(b.min_y);
            lo[2] = q88_t'(b.min_z);
            hi[0] = q88_t'(b.max_x);
            hi[1] = q88_t'(b.max_y);
            hi[2] = q88_t'(b.max_z);
            live = (plane_count > MAX_PLANES) ? MAX_PLANES : plane_count;
            for (int p = 0; p < live; p++) begin
                nrm[0] = q88_t'(planes[p].nx);
                nrm[1] = q88_t'(planes[p].ny);
                nrm[2] = q88_t'(planes[p].nz);
                acc = longint'(q88_t'(planes[p].offset)) * 256;
                for (int a = 0; a < 3; a++) begin
                    acc += nrm[a] * ((nrm[a] > 0) ? hi[a] : lo[a]);
                end
                if (acc < 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_box(box_t b, logic lastb);
            verdict_t v;
            v.is_in = box_inside(b);
            v.last_flag = lastb;
            verdicts_due.push_back(v);
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        task flag_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic got_in, logic lastb);
            verdict_t v;
            if (verdicts_due.size() == 0) begin
                flag_mismatch("result with no request pending");
            end else begin
                v = verdicts_due.pop_front();
                if (got_in !== v.is_in)
                    flag_mismatch($sformatf("inside_res got %b want %b", got_in, v.is_in));
                if (lastb !== v.last_flag)
                    flag_mismatch($sformatf("last_result got %b want %b", lastb, v.last_flag));
            end
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_box_min_x = '0;
    logic signed [15:0] s_box_min_y = '0;
    logic signed [15:0] s_box_min_z = '0;
    logic signed [15:0] s_box_max_x = '0;
    logic signed [15:0] s_box_max_y = '0;
    logic signed [15:0] s_box_max_z = '0;
    logic s_last_box = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_inside_res;
    logic m_last_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    cull_scoreboard board;
    int send_gap_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int cycles = 0;

    aabb_frustum_cull_test dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_box_min_x(s_box_min_x),
        .s_box_min_y(s_box_min_y),
        .s_box_min_z(s_box_min_z),
        .s_box_max_x(s_box_max_x),
        .s_box_max_y(s_box_max_y),
        .s_box_max_z(s_box_max_z),
        .s_last_box(s_last_box),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_inside_res(m_inside_res),
        .m_last_result(m_last_result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The long hold-off is armed on a falling edge and counted down here.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_inside_res, m_last_result);
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic box_t mk_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
        box_t b;
        b.min_x = q88_t'(mnx);
        b.min_y = q88_t'(mny);
        b.min_z = q88_t'(mnz);
        b.max_x = q88_t'(mxx);
        b.max_y = q88_t'(mxy);
        b.max_z = q88_t'(mxz);
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] mk_plane(int nx, int ny, int nz, int offset);
        return {q88_t'(offset), q88_t'(nz), q88_t'(ny), q88_t'(nx)};
    endfunction

    function automatic box_t random_box();
        int c[3];
        int e[3];
        int ext[5];
        int pick;
        ext = '{-32768, 32767, 0, -1, 1};
        pick = $urandom_range(99);
        for (int a = 0; a < 3; a++) begin
            c[a] = int'($urandom_range(32767)) - 16384;
            e[a] = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(255);
        end
        if (pick < 80)
            return mk_box(c[0] - e[0], c[1] - e[1], c[2] - e[2],
                          c[0] + e[0], c[1] + e[1], c[2] + e[2]);
        if (pick < 90)
            return box_t'({$urandom, $urandom, $urandom});
        return mk_box(ext[$urandom_range(4)], ext[$urandom_range(4)], ext[$urandom_range(4)],
                      ext[$urandom_range(4)], ext[$urandom_range(4)], ext[$urandom_range(4)]);
    endfunction

    function automatic logic [DATA_W-1:0] random_plane();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return mk_plane(int'($urandom_range(512)) - 256, int'($urandom_range(512)) - 256,
                            int'($urandom_range(512)) - 256, int'($urandom_range(20479)) - 4096);
        if (pick < 90)
            return {$urandom, $urandom};
        return '0;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_box(box_t b, logic lastb);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_box_min_x <= b.min_x;
        s_box_min_y <= b.min_y;
        s_box_min_z <= b.min_z;
        s_box_max_x <= b.max_x;
        s_box_max_y <= b.max_y;
        s_box_max_z <= b.max_z;
        s_last_box <= lastb;
        do @(posedge aclk); while (!s_ready);
        board.note_box(b, lastb);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        int counts[8];
        int gaps[4];
        int stalls[4];
        counts = '{1, 6, 3, 0, 7, 2, 5, 4};
        gaps = '{0, 49, 0, 37};
        stalls = '{0, 0, 49, 37};
        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset planes are all zero and never reject a box.
        push_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 1'b0);
        push_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768), 1'b1);
        drain();

        // A sum of exactly zero counts as inside; swapped corners are used as given.
        write_reg(REG_PLANE_COUNT, 64'd1);
        write_reg(REG_PLANE_ZERO, mk_plane(256, 0, 0, 0));
        push_box(mk_box(-5, 0, 0, 0, 0, 0), 1'b0);
        push_box(mk_box(-5, 0, 0, -1, 0, 0), 1'b0);
        push_box(mk_box(100, 0, 0, -100, 0, 0), 1'b1);
        drain();

        // Negative normal component selects the min corner; zero components drop out.
        write_reg(REG_PLANE_ZERO, mk_plane(0, -256, 0, 256));
        push_box(mk_box(0, 256, 0, 0, 300, 0), 1'b0);
        push_box(mk_box(0, 257, 0, 0, 300, 0), 1'b1);
        drain();

        // Full-scale operands, with a plane count above the number of planes.
        write_reg(REG_PLANE_COUNT, 64'd7);
        write_reg(REG_PLANE_ZERO, mk_plane(32767, 32767, 32767, -32768));
        push_box(mk_box(0, 0, 0, -32768, -32768, -32768), 1'b0);
        push_box(mk_box(0, 0, 0, 32767, 32767, 32767), 1'b0);
        drain();
        write_reg(REG_PLANE_ZERO, mk_plane(-32768, -32768, -32768, -32768));
        push_box(mk_box(-32768, -32768, -32768, 0, 0, 0), 1'b0);
        push_box(mk_box(32767, 32767, 32767, 0, 0, 0), 1'b1);
        drain();

        // No planes in use: everything is inside.
        write_reg(REG_PLANE_COUNT, 64'd0);
        push_box(mk_box(32767, 32767, 32767, 0, 0, 0), 1'b1);
        drain();

        // Writes to the spare index are ignored; the last plane alone can reject.
        write_reg(REG_UNUSED, '1);
        write_reg(REG_PLANE_COUNT, 64'd6);
        write_reg(REG_PLANE_ZERO, '0);
        write_reg(REG_PLANE_FIVE, mk_plane(0, 0, 256, 0));
        push_box(mk_box(0, 0, -10, 0, 0, -1), 1'b0);
        push_box(mk_box(0, 0, -10, 0, 0, 32767), 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_PLANE_COUNT, DATA_W'(counts[ph]));
            for (int p = 0; p < MAX_PLANES; p++)
                write_reg(IDX_W'(REG_PLANE_ZERO + p), random_plane());
            if (ph == 5)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            send_gap_pct = gaps[ph % 4];
            stall_pct = stalls[ph % 4];
            repeat (170) push_box(random_box(), $urandom_range(7) == 0);
            drain();
        end

        // The receiver holds off long enough for the block to back up its input.
        write_reg(REG_PLANE_COUNT, 64'd6);
        send_gap_pct = 0;
        stall_pct = 0;
        @(negedge aclk);
        hold_left = 300;
        @(posedge aclk);
        repeat (60) push_box(random_box(), $urandom_range(7) == 0);
        drain();
        repeat (10) @(posedge aclk);

        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ aabb_frustum_cull_test.f @@
src/aafc_pkg.sv
src/aafc_cfg_regs.sv
src/aafc_plane_eval.sv
src/aabb_frustum_cull_test.sv
tb/sv/aabb_frustum_cull_test_test.sv
